// ----- src/ihex_pkg.sv -----
package ihex_pkg;

   // Result kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_DIGIT     = 2'd0;
   localparam logic [1:0] ERR_CHECKSUM  = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;

   // Record types
   localparam logic [7:0] REC_DATA          = 8'h00;
   localparam logic [7:0] REC_EOF           = 8'h01;
   localparam logic [7:0] REC_EXT_SEGMENT   = 8'h02;
   localparam logic [7:0] REC_START_SEGMENT = 8'h03;
   localparam logic [7:0] REC_EXT_LINEAR    = 8'h04;
   localparam logic [7:0] REC_START_LINEAR  = 8'h05;

   // Header bytes: count, offset high, offset low, type
   localparam logic [1:0] SLOT_COUNT      = 2'd0;
   localparam logic [1:0] SLOT_OFFSET_HI  = 2'd1;
   localparam logic [1:0] SLOT_OFFSET_LO  = 2'd2;
   localparam logic [1:0] SLOT_TYPE       = 2'd3;

   localparam logic [3:0] HEADER_DIGITS   = 4'd8;
   localparam logic [7:0] COLON_CHAR      = 8'h3a;
   localparam int         QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic       is_colon;
      logic       is_hex;
      logic [3:0] value;
   } token_type;

   function automatic token_type classify_char(input logic [7:0] c);
      token_type t;
      t.is_colon = (c == COLON_CHAR);
      t.is_hex   = 1'b0;
      t.value    = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t.is_hex = 1'b1;
         t.value  = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t.is_hex = 1'b1;
         t.value  = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t.is_hex = 1'b1;
         t.value  = 4'(c - 8'h57);
      end
      return t;
   endfunction

endpackage

// ----- src/ihex_front.sv -----
module ihex_front #(
   parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_code,
   output logic                 tok_valid,
   output ihex_pkg::token_type  tok_data,
   input  logic                 tok_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ihex_pkg::token_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push;

   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign tok_valid = (count_ff != '0);
   assign tok_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (tok_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !tok_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && tok_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Classify on the way in
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= ihex_pkg::classify_char(req_char_code);
      end
   end

endmodule

// ----- src/ihex_back.sv -----
module ihex_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  logic                 tok_valid,
   input  ihex_pkg::token_type  tok_data,
   output logic                 tok_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [31:0]          rsp_address,
   output logic [7:0]           rsp_data,
   output logic [1:0]           rsp_error_code
);

   logic        ignore_ff;
   logic [3:0]  digit_ff, digit_in;
   logic [3:0]  partial_ff, partial_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  rec_type_ff, rec_type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] base_ff, base_in;
   logic [15:0] ext_ff, ext_in;
   logic [7:0]  index_ff, index_in;
   logic        in_record_ff, in_record_in;
   logic        halted_ff, halted_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [31:0] rsp_address_ff;
   logic [7:0]  rsp_data_ff;
   logic [1:0]  rsp_error_ff;

   logic        emit;
   logic [1:0]  res_kind;
   logic [31:0] res_address;
   logic [7:0]  res_data;
   logic [1:0]  res_error;
   logic [7:0]  byte_val;
   logic [7:0]  sum_new;

   assign tok_pop = tok_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      digit_in     = digit_ff;
      partial_in   = partial_ff;
      length_in    = length_ff;
      offset_in    = offset_ff;
      rec_type_in  = rec_type_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      ext_in       = ext_ff;
      index_in     = index_ff;
      in_record_in = in_record_ff;
      halted_in    = halted_ff;
      emit         = 1'b0;
      res_kind     = ihex_pkg::KIND_WRITE;
      res_address  = '0;
      res_data     = '0;
      res_error    = ihex_pkg::ERR_DIGIT;
      byte_val     = {partial_ff, tok_data.value};
      sum_new      = sum_ff + byte_val;

      if (tok_pop && !halted_ff) begin
         if (!in_record_ff) begin
            if (tok_data.is_colon) begin
               in_record_in = 1'b1;
               digit_in     = '0;
               partial_in   = '0;
               length_in    = '0;
               offset_in    = '0;
               rec_type_in  = ihex_pkg::REC_DATA;
               sum_in       = '0;
               ext_in       = '0;
               index_in     = '0;
            end
         end else if (!tok_data.is_hex) begin
            halted_in    = 1'b1;
            in_record_in = 1'b0;
            emit         = 1'b1;
            res_kind     = ihex_pkg::KIND_ERROR;
            res_error    = ihex_pkg::ERR_DIGIT;
         end else if (!digit_ff[0]) begin
            partial_in = tok_data.value;
            digit_in   = digit_ff + 1'b1;
         end else begin
            sum_in = sum_new;
            if (digit_ff < ihex_pkg::HEADER_DIGITS) begin
               digit_in = digit_ff + 1'b1;
               unique case (digit_ff[2:1])
                  ihex_pkg::SLOT_COUNT:     length_in = byte_val;
                  ihex_pkg::SLOT_OFFSET_HI: offset_in = {byte_val, 8'h00};
                  ihex_pkg::SLOT_OFFSET_LO: offset_in = {offset_ff[15:8], byte_val};
                  ihex_pkg::SLOT_TYPE: begin
                     rec_type_in = byte_val;
                     priority if (byte_val == ihex_pkg::REC_EOF ||
                                  byte_val > ihex_pkg::REC_START_LINEAR) begin
                        halted_in    = 1'b1;
                        in_record_in = 1'b0;
                        emit         = 1'b1;
                        res_kind     = ihex_pkg::KIND_END;
                     end else if (byte_val == ihex_pkg::REC_START_SEGMENT ||
                                  byte_val == ihex_pkg::REC_START_LINEAR) begin
                        in_record_in = 1'b0;
                     end else if (byte_val != ihex_pkg::REC_DATA &&
                                  (length_ff != 8'd2 || offset_ff != 16'd0)) begin
                        halted_in    = 1'b1;
                        in_record_in = 1'b0;
                        emit         = 1'b1;
                        res_kind     = ihex_pkg::KIND_ERROR;
                        res_error    = ihex_pkg::ERR_MALFORMED;
                     end else begin
                        halted_in = halted_ff;
                     end
                  end
                  default: length_in = length_ff;
               endcase
            end else begin
               digit_in = ihex_pkg::HEADER_DIGITS;
               if (index_ff < length_ff) begin
                  index_in = index_ff + 1'b1;
                  if (rec_type_ff == ihex_pkg::REC_DATA) begin
                     emit        = 1'b1;
                     res_kind    = ihex_pkg::KIND_WRITE;
                     res_address = base_ff + {16'h0000, offset_ff} + {24'h000000, index_ff};
                     res_data    = byte_val;
                  end else begin
                     ext_in = {ext_ff[7:0], byte_val};
                  end
               end else begin
                  // Checksum byte closes the record
                  in_record_in = 1'b0;
                  if (sum_new != 8'h00) begin
                     if (!(rec_type_ff == ihex_pkg::REC_DATA && ignore_ff)) begin
                        halted_in = 1'b1;
                        emit      = 1'b1;
                        res_kind  = ihex_pkg::KIND_ERROR;
                        res_error = ihex_pkg::ERR_CHECKSUM;
                     end
                  end else if (rec_type_ff == ihex_pkg::REC_EXT_SEGMENT) begin
                     base_in = {12'h000, ext_ff, 4'h0};
                  end else if (rec_type_ff == ihex_pkg::REC_EXT_LINEAR) begin
                     base_in = {ext_ff, 16'h0000};
                  end
               end
            end
         end
      end

      if (tok_pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff    <= 1'b0;
         digit_ff     <= '0;
         partial_ff   <= '0;
         length_ff    <= '0;
         offset_ff    <= '0;
         rec_type_ff  <= ihex_pkg::REC_DATA;
         sum_ff       <= '0;
         base_ff      <= '0;
         ext_ff       <= '0;
         index_ff     <= '0;
         in_record_ff <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ignore_ff <= csr_write_data;
         end
         digit_ff     <= digit_in;
         partial_ff   <= partial_in;
         length_ff    <= length_in;
         offset_ff    <= offset_in;
         rec_type_ff  <= rec_type_in;
         sum_ff       <= sum_in;
         base_ff      <= base_in;
         ext_ff       <= ext_in;
         index_ff     <= index_in;
         in_record_ff <= in_record_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && emit) begin
         rsp_kind_ff    <= res_kind;
         rsp_address_ff <= res_address;
         rsp_data_ff    <= res_data;
         rsp_error_ff   <= res_error;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_error_code = rsp_error_ff;

endmodule

// ----- src/intel_hex_record_decoder_unit.sv -----
// Path: an accepted character is classified into the character queue register,
//   and is then decoded from the queue into the result register.
// Throughput: one character per cycle while rsp_stall holds no result back.
// Reset: synchronous, active high; clears the queue, the decoder state, the base
//   address and the ignore-checksum register, and drops any pending result.
module intel_hex_record_decoder_unit #(
   parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Character input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   // Result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data,
   output logic [1:0]  rsp_error_code,
   // Configuration
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   // Tokens handed from the classifier queue to the record decoder
   logic                tok_valid;
   logic                tok_pop;
   ihex_pkg::token_type tok_data;

   // Front: take one transaction per cycle while not full, classify the character
   // (colon, hex digit and its value, anything else) and hold it in a short queue.
   // The queue lets input keep flowing while a result waits on rsp_stall.
   ihex_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .tok_valid     (tok_valid),
      .tok_data      (tok_data),
      .tok_pop       (tok_pop)
   );

   // Back: advance the record state one token per cycle, emit byte writes,
   // end-of-stream and errors into the result register, and halt after the
   // end or an error. It pops a token whenever the result register is free
   // or being drained in the same cycle.
   ihex_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tok_valid        (tok_valid),
      .tok_data         (tok_data),
      .tok_pop          (tok_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_address      (rsp_address),
      .rsp_data         (rsp_data),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

// ----- src/ihex_checker.sv -----
module ihex_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_address,
   input logic [7:0]  rsp_data,
   input logic [1:0]  rsp_error_code
);

   // Nothing follows an end or error transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall &&
       (rsp_kind == ihex_pkg::KIND_END || rsp_kind == ihex_pkg::KIND_ERROR))
      |=> !rsp_valid)
      else $error("result after end or error");

   // Non-write results carry zero address and data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != ihex_pkg::KIND_WRITE)
      |-> (rsp_address == 32'd0 && rsp_data == 8'd0))
      else $error("non-write result with address or data");

   // Error code only on error results, and kind is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == ihex_pkg::KIND_ERROR) ||
                     ((rsp_kind == ihex_pkg::KIND_WRITE || rsp_kind == ihex_pkg::KIND_END) &&
                      rsp_error_code == ihex_pkg::ERR_DIGIT)))
      else $error("bad kind or stray error code");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_address) &&
                                    $stable(rsp_data) && $stable(rsp_error_code)))
      else $error("stalled result changed");

   // Stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_char_code)))
      else $error("stalled character changed");

endmodule

bind intel_hex_record_decoder_unit ihex_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_char_code    (req_char_code),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_address      (rsp_address),
   .rsp_data         (rsp_data),
   .rsp_error_code   (rsp_error_code)
);
